// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of the group reverser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/sgr_pkg.sv =====
// ----------------------------------------------------------------------------
// sgr_pkg
// Constants, types and helpers shared by the stream group reverser.
// ----------------------------------------------------------------------------
package sgr_pkg;

   localparam int MAX_GROUP = 16;
   localparam int IDX_W     = $clog2(MAX_GROUP);
   localparam int CNT_W     = IDX_W + 1;
   localparam int VALUE_W   = 16;
   localparam int SIZE_W    = 5;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               run_last;
      logic               list_last;
   } rsp_item_type;

   // A group size of zero acts as one; sizes above the buffer depth saturate.
   function automatic logic [CNT_W-1:0] effective_size(input logic [SIZE_W-1:0] size);
      logic [CNT_W-1:0] result;
      if (size == '0) begin
         result = CNT_W'(1);
      end else if (CNT_W'(size) > CNT_W'(MAX_GROUP)) begin
         result = CNT_W'(MAX_GROUP);
      end else begin
         result = CNT_W'(size);
      end
      return result;
   endfunction

endpackage

// ===== rtl/sgr_req_if.sv =====
// ----------------------------------------------------------------------------
// sgr_req_if
// Request channel of the group reverser: one list node per request.
// ----------------------------------------------------------------------------
interface sgr_req_if;
   logic                        valid;
   logic                        ready;
   logic [sgr_pkg::VALUE_W-1:0] item_value;
   logic                        list_end;

   modport source (output valid, output item_value, output list_end, input ready);
   modport sink (input valid, input item_value, input list_end, output ready);
endinterface

// ===== rtl/sgr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sgr_rsp_if
// Response channel of the group reverser: one reordered node per response.
// ----------------------------------------------------------------------------
interface sgr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sgr_pkg::VALUE_W-1:0] out_value;
   logic                        run_last;
   logic                        list_last;

   modport source (output valid, output out_value, output run_last, output list_last,
                   input ready);
   modport sink (input valid, input out_value, input run_last, input list_last,
                 output ready);
endinterface

// ===== rtl/sgr_rsp_stage.sv =====
// ----------------------------------------------------------------------------
// sgr_rsp_stage
// Two-entry output buffer that decouples buffer reads from response stalls.
// ----------------------------------------------------------------------------
module sgr_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  sgr_pkg::rsp_item_type push_item,
   output logic                  issue_ok,
   sgr_rsp_if.source             rsp_bus
);
   import sgr_pkg::*;

   rsp_item_type head_ff, head_in;
   rsp_item_type tail_ff, tail_in;
   logic         head_vld_ff, head_vld_in;
   logic         tail_vld_ff, tail_vld_in;
   logic         pop;
   logic [1:0]   pending;

   assign pop     = head_vld_ff & rsp_bus.ready;
   assign pending = 2'(head_vld_ff) + 2'(tail_vld_ff) + 2'(push_valid) - 2'(pop);

   // A read issued now lands here next cycle; it must find a free entry.
   assign issue_ok = pending <= 2'd1;

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      head_vld_in = head_vld_ff;
      tail_vld_in = tail_vld_ff;
      if (pop) begin
         if (tail_vld_ff) begin
            head_in     = tail_ff;
            head_vld_in = 1'b1;
            tail_in     = push_item;
            tail_vld_in = push_valid;
         end else begin
            head_in     = push_item;
            head_vld_in = push_valid;
         end
      end else if (push_valid) begin
         if (!head_vld_ff) begin
            head_in     = push_item;
            head_vld_in = 1'b1;
         end else begin
            tail_in     = push_item;
            tail_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         tail_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         tail_vld_ff <= tail_vld_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_bus.valid     = head_vld_ff;
   assign rsp_bus.out_value = head_ff.value;
   assign rsp_bus.run_last  = head_ff.run_last;
   assign rsp_bus.list_last = head_ff.list_last;

endmodule

// ===== rtl/stream_group_reverser.sv =====
// ----------------------------------------------------------------------------
// stream_group_reverser
// Reverses a stream of list values in groups of group_size; a short tail at
// the list end is passed on in its original order.
// ----------------------------------------------------------------------------
// A request that neither completes a group nor ends the list is stored in the group buffer.
// A request that completes a group or ends the list releases n values, which
// are then read out of the group buffer, a single-port memory that gives one
// value per cycle while the response stage has room; during that time no new
// request is taken, while responses already read keep draining.
`include "assert_macros.svh"

module stream_group_reverser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [sgr_pkg::SIZE_W-1:0] csr_wr_data,
   sgr_req_if.sink                    req_bus,
   sgr_rsp_if.source                  rsp_bus
);
   import sgr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   logic [VALUE_W-1:0] group_mem [MAX_GROUP];

   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  group_size_ff, group_size_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               rev_ff, rev_in;
   logic               end_ff, end_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rd_last_ff, rd_last_in;
   logic               rd_list_ff, rd_list_in;
   logic [VALUE_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]   size_eff;
   logic [CNT_W-1:0]   fill_next;
   logic               accept;
   logic               group_done;
   logic               release_now;
   logic               issue_ok;
   logic               issue;
   logic               last_read;
   logic [IDX_W-1:0]   rd_addr;
   rsp_item_type       push_item;

   assign size_eff    = effective_size(group_size_ff);
   assign fill_next   = fill_ff + CNT_W'(1);
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept      = req_bus.valid & req_bus.ready;
   assign group_done  = fill_next >= size_eff;
   assign release_now = group_done | req_bus.list_end;
   assign issue       = (state_ff == ST_EMIT) & issue_ok;
   assign last_read   = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign rd_addr     = rev_ff ? IDX_W'(count_ff - CNT_W'(1) - CNT_W'(idx_ff)) : idx_ff;

   always_comb begin
      state_in      = state_ff;
      group_size_in = group_size_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rev_in        = rev_ff;
      end_in        = end_ff;
      rd_vld_in     = issue;
      rd_last_in    = rd_last_ff;
      rd_list_in    = rd_list_ff;
      if (csr_wr_en) begin
         group_size_in = csr_wr_data;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (release_now) begin
                  fill_in  = '0;
                  count_in = fill_next;
                  idx_in   = '0;
                  rev_in   = group_done;
                  end_in   = req_bus.list_end;
                  state_in = ST_EMIT;
               end else begin
                  fill_in = fill_next;
               end
            end
         end
         ST_EMIT: begin
            if (issue) begin
               rd_last_in = last_read;
               rd_list_in = last_read & end_ff;
               idx_in     = idx_ff + IDX_W'(1);
               if (last_read) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         group_size_ff <= SIZE_W'(1);
         fill_ff       <= '0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         group_size_ff <= group_size_in;
         fill_ff       <= fill_in;
         rd_vld_ff     <= rd_vld_in;
      end
      count_ff   <= count_in;
      idx_ff     <= idx_in;
      rev_ff     <= rev_in;
      end_ff     <= end_in;
      rd_last_ff <= rd_last_in;
      rd_list_ff <= rd_list_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         group_mem[fill_ff[IDX_W-1:0]] <= req_bus.item_value;
      end
      if (issue) begin
         rd_data_ff <= group_mem[rd_addr];
      end
   end

   assign push_item.value     = rd_data_ff;
   assign push_item.run_last  = rd_last_ff;
   assign push_item.list_last = rd_list_ff;

   sgr_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .push_valid (rd_vld_ff),
      .push_item  (push_item),
      .issue_ok   (issue_ok),
      .rsp_bus    (rsp_bus)
   );

   `ASSERT_IMPLY(a_fill_below_depth, clock, reset, 1'b1, fill_ff < CNT_W'(MAX_GROUP))
   `ASSERT_NEXT(a_release_enters_emit, clock, reset, accept && release_now, state_ff == ST_EMIT)
   `ASSERT_IMPLY(a_list_last_ends_run, clock, reset, rsp_bus.valid && rsp_bus.list_last,
                 rsp_bus.run_last)
   `ASSERT_NEXT(a_issue_follows_count, clock, reset, issue && last_read, state_ff == ST_IDLE)

endmodule

// ===== test/tb_stream_group_reverser.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stream_group_reverser
// Drives list nodes into the group reverser under several group sizes and
// compares every response, field by field, with a behavioral model of k-group
// reversal run alongside the block, or with a typed row. Directed rows come
// first, then random lists, with random stalls on both channels in most phases.
// ----------------------------------------------------------------------------
module tb_stream_group_reverser;
   import sgr_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 20;
   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 80;
   localparam int IDLE_PERCENT  = 15;

   typedef struct packed {
      logic               set_size;
      logic [SIZE_W-1:0]  size;
      logic [VALUE_W-1:0] value;
      logic               list_end;
      logic               typed;
      rsp_item_type       rsp;
   } stim_row_type;

   localparam int N_ROWS = 19;

   stim_row_type directed_rows [N_ROWS] = '{
      '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b0}},
      '{1'b0, 5'd0,  16'hffff, 1'b1, 1'b1, '{16'hffff, 1'b1, 1'b1}},
      '{1'b1, 5'd0,  16'h1234, 1'b0, 1'b1, '{16'h1234, 1'b1, 1'b0}},
      '{1'b1, 5'd3,  16'h0001, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h0002, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h0003, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h0004, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h0005, 1'b1, 1'b0, '0},
      '{1'b0, 5'd0,  16'h0006, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h0007, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h0008, 1'b1, 1'b0, '0},
      '{1'b0, 5'd0,  16'haaaa, 1'b1, 1'b1, '{16'haaaa, 1'b1, 1'b1}},
      '{1'b1, 5'd4,  16'h000a, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h000b, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h000c, 1'b0, 1'b0, '0},
      '{1'b1, 5'd2,  16'h000d, 1'b0, 1'b0, '0},
      '{1'b1, 5'd31, 16'h5555, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h8000, 1'b1, 1'b0, '0},
      '{1'b1, 5'd16, 16'h7fff, 1'b1, 1'b1, '{16'h7fff, 1'b1, 1'b1}}
   };

   localparam int N_PHASES = 10;
   localparam logic [SIZE_W-1:0] PHASE_SIZES [N_PHASES] =
      '{5'd2, 5'd16, 5'd5, 5'd31, 5'd1, 5'd0, 5'd7, 5'd4, 5'd17, 5'd3};
   localparam int QUIET_PHASE    = 2;
   localparam int PRESSURE_PHASE = 7;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;

   sgr_req_if req_bus ();
   sgr_rsp_if rsp_bus ();

   logic [SIZE_W-1:0]  model_size;
   logic [VALUE_W-1:0] model_buffer [MAX_GROUP];
   int                 model_fill;
   rsp_item_type       released_nodes [$];
   rsp_item_type       expected_nodes [$];

   int  error_count = 0;
   int  response_count = 0;
   int  quiet_cycles = 0;
   bit  idle_on;
   int  phase_index;

   stream_group_reverser u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   function automatic int group_span(input logic [SIZE_W-1:0] size);
      int span;
      span = int'(size);
      if (span == 0) begin
         span = 1;
      end else if (span > MAX_GROUP) begin
         span = MAX_GROUP;
      end
      return span;
   endfunction

   // Fills released_nodes with the responses that one accepted request causes.
   function automatic void reorder_node(input logic [VALUE_W-1:0] value, input logic list_end);
      int span;
      int count;
      span = group_span(model_size);
      released_nodes.delete();
      if (model_fill < MAX_GROUP) begin
         model_buffer[model_fill] = value;
         model_fill++;
      end
      count = model_fill;
      if (count >= span) begin
         for (int i = 0; i < count; i++) begin
            released_nodes.push_back('{model_buffer[count - 1 - i], i == count - 1,
                                       (i == count - 1) && list_end});
         end
         model_fill = 0;
      end else if (list_end) begin
         for (int i = 0; i < count; i++) begin
            released_nodes.push_back('{model_buffer[i], i == count - 1, i == count - 1});
         end
         model_fill = 0;
      end
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("response %0d: %s is %h, expected %h", response_count, field, got, want);
      error_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_node(input logic [VALUE_W-1:0] value, input logic list_end,
                            input logic typed, input rsp_item_type typed_rsp);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.item_value <= value;
      req_bus.list_end   <= list_end;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      reorder_node(value, list_end);
      if (typed) begin
         expected_nodes.push_back(typed_rsp);
      end else begin
         foreach (released_nodes[i]) begin
            expected_nodes.push_back(released_nodes[i]);
         end
      end
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_nodes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] size);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      model_size  = size;
   endtask

   initial begin
      bit hold_done;
      hold_done     = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (phase_index == PRESSURE_PHASE && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_bus.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_nodes.size() == 0) begin
            report_mismatch("unexpected out_value", int'(rsp_bus.out_value), 0);
         end else begin
            want = expected_nodes.pop_front();
            if (rsp_bus.out_value !== want.value) begin
               report_mismatch("out_value", int'(rsp_bus.out_value), int'(want.value));
            end
            if (rsp_bus.run_last !== want.run_last) begin
               report_mismatch("run_last", int'(rsp_bus.run_last), int'(want.run_last));
            end
            if (rsp_bus.list_last !== want.list_last) begin
               report_mismatch("list_last", int'(rsp_bus.list_last), int'(want.list_last));
            end
         end
         response_count++;
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_stream_group_reverser failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int span;
      int n_items;
      logic [VALUE_W-1:0] value;
      logic list_end;
      idle_on            = 1'b1;
      phase_index        = -1;
      model_size         = 5'd1;
      model_fill         = 0;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.item_value = '0;
      req_bus.list_end   = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].set_size) begin
            wait_idle();
            write_size(directed_rows[r].size);
         end
         send_node(directed_rows[r].value, directed_rows[r].list_end,
                   directed_rows[r].typed, directed_rows[r].rsp);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         wait_idle();
         write_size(PHASE_SIZES[p]);
         idle_on      = (p != QUIET_PHASE);
         phase_index  = p;
         span         = group_span(PHASE_SIZES[p]);
         n_items      = (span >= MAX_GROUP) ? 30 : 15;
         for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(0, 9))
               0: begin
                  value = '0;
               end
               1: begin
                  value = '1;
               end
               default: begin
                  value = VALUE_W'($urandom);
               end
            endcase
            list_end = ($urandom_range(0, 2 * span + 2) == 0);
            send_node(value, list_end, 1'b0, '0);
         end
      end

      idle_on = 1'b1;
      wait_idle();
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_stream_group_reverser passed");
      end else begin
         $display("tb_stream_group_reverser failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sgr_pkg.sv
rtl/sgr_req_if.sv
rtl/sgr_rsp_if.sv
rtl/sgr_rsp_stage.sv
rtl/stream_group_reverser.sv
test/tb_stream_group_reverser.sv
